[src/bwsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_pkg
// Shared types and constants of the box and wall segment collision unit.
// ----------------------------------------------------------------------------
package bwsc_pkg;

    typedef enum logic [0:0] {
        CMD_WALL = 1'b0,
        CMD_TEST = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_back_state;

    localparam int CMD_BITS  = 1;
    localparam int SLOT_BITS = 6;
    localparam int CFG_BITS  = 7;
    localparam int NUM_SIDES = 4;

    // box sides as corner pairs: 0-2, 1-3, 0-1, 2-3 (entry 0 is rightmost)
    localparam logic [NUM_SIDES-1:0][1:0] SIDE_A = {2'd2, 2'd0, 2'd1, 2'd0};
    localparam logic [NUM_SIDES-1:0][1:0] SIDE_B = {2'd3, 2'd1, 2'd3, 2'd2};

endpackage

[src/bwsc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_queue
// Two-entry queue that decouples the front end from the test engine.
// ----------------------------------------------------------------------------
module bwsc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [W-1:0] r_mem [DEPTH];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_cnt;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_cnt == 2'(DEPTH));
    assign o_valid   = (r_cnt != 2'd0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/bwsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_front
// Accepts input words, drops wall writes to slots beyond the store and
// packs the rest into queue words.
// ----------------------------------------------------------------------------
module bwsc_front #(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 16,
    parameter int AW         = 6,
    parameter int QW         = 1 + AW + 8 * COORD_BITS
) (
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [bwsc_pkg::CMD_BITS-1:0]      i_cmd,
    input  logic [bwsc_pkg::SLOT_BITS-1:0]     i_wall_slot,
    input  logic signed [COORD_BITS-1:0]       i_corner0_x,
    input  logic signed [COORD_BITS-1:0]       i_corner0_y,
    input  logic signed [COORD_BITS-1:0]       i_corner1_x,
    input  logic signed [COORD_BITS-1:0]       i_corner1_y,
    input  logic signed [COORD_BITS-1:0]       i_corner2_x,
    input  logic signed [COORD_BITS-1:0]       i_corner2_y,
    input  logic signed [COORD_BITS-1:0]       i_corner3_x,
    input  logic signed [COORD_BITS-1:0]       i_corner3_y,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output logic [QW-1:0]                      o_q_data
);

    bwsc_pkg::t_cmd w_cmd;
    logic           w_slot_ok;
    logic           w_keep;

    assign w_cmd     = bwsc_pkg::t_cmd'(i_cmd);
    assign w_slot_ok = (32'(i_wall_slot) < 32'(MAX_WALLS));
    assign w_keep    = (w_cmd == bwsc_pkg::CMD_TEST) || w_slot_ok;

    assign o_full   = i_q_full;
    // out of range wall writes are accepted and dropped here
    assign o_q_push = i_push && !i_q_full && w_keep;
    assign o_q_data = {i_cmd, AW'(i_wall_slot),
                       i_corner0_x, i_corner0_y, i_corner1_x, i_corner1_y,
                       i_corner2_x, i_corner2_y, i_corner3_x, i_corner3_y};

endmodule

[src/bwsc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_back
// Wall store and pipelined segment test engine, one wall per cycle, with
// the result register.
// ----------------------------------------------------------------------------
module bwsc_back #(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 16,
    parameter int AW         = 6,
    parameter int QW         = 1 + AW + 8 * COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [QW-1:0]                 i_q_data,
    output logic                          o_q_pop,
    input  logic [bwsc_pkg::CFG_BITS-1:0] i_wall_count,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_hit
);

    localparam int CB = COORD_BITS;
    localparam int CW = $clog2(MAX_WALLS + 1);
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int EW = PW + 1;
    localparam int NS = bwsc_pkg::NUM_SIDES;

    function automatic logic in_unit(input logic signed [EW-1:0] n,
                                     input logic signed [EW-1:0] d);
        logic r;
        if (d > 0) begin
            r = (n >= 0) && (n <= d);
        end else begin
            r = (n <= 0) && (n >= d);
        end
        return r;
    endfunction

    bwsc_pkg::t_back_state r_state;
    bwsc_pkg::t_back_state n_state;

    logic [4*CB-1:0]        r_mem [MAX_WALLS];
    logic [4*CB-1:0]        r_rd;
    logic [3:0]             r_vld;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_n;
    logic signed [CB-1:0]   r_bx [4];
    logic signed [CB-1:0]   r_by [4];
    logic                   r_hit;
    logic                   r_out_valid;
    logic                   r_out_hit;

    logic signed [DW-1:0]   r_sx;
    logic signed [DW-1:0]   r_sy;
    logic signed [DW-1:0]   r_rx [NS];
    logic signed [DW-1:0]   r_ry [NS];
    logic signed [DW-1:0]   r_qx [NS];
    logic signed [DW-1:0]   r_qy [NS];
    logic signed [PW-1:0]   r_pd1 [NS];
    logic signed [PW-1:0]   r_pd2 [NS];
    logic signed [PW-1:0]   r_pa1 [NS];
    logic signed [PW-1:0]   r_pa2 [NS];
    logic signed [PW-1:0]   r_pb1 [NS];
    logic signed [PW-1:0]   r_pb2 [NS];
    logic signed [EW-1:0]   r_d  [NS];
    logic signed [EW-1:0]   r_na [NS];
    logic signed [EW-1:0]   r_nb [NS];

    logic                   w_is_test;
    logic                   w_mem_we;
    logic                   w_latch;
    logic                   w_issue;
    logic                   w_load_out;
    logic [AW-1:0]          w_waddr;
    logic signed [CB-1:0]   w_wx0;
    logic signed [CB-1:0]   w_wy0;
    logic signed [CB-1:0]   w_wx1;
    logic signed [CB-1:0]   w_wy1;
    logic [NS-1:0]          w_cross;

    assign w_is_test = (i_q_data[QW-1] == bwsc_pkg::CMD_TEST);
    assign w_waddr   = i_q_data[QW-2 -: AW];
    assign w_wx0     = r_rd[4*CB-1 -: CB];
    assign w_wy0     = r_rd[3*CB-1 -: CB];
    assign w_wx1     = r_rd[2*CB-1 -: CB];
    assign w_wy1     = r_rd[CB-1 -: CB];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bwsc_pkg::ST_IDLE: begin
                if (i_q_valid && w_is_test) begin
                    n_state = bwsc_pkg::ST_RUN;
                end
            end
            bwsc_pkg::ST_RUN: begin
                if (r_idx == r_n) begin
                    n_state = bwsc_pkg::ST_DRAIN;
                end
            end
            bwsc_pkg::ST_DRAIN: begin
                if (r_vld == 4'd0) begin
                    n_state = bwsc_pkg::ST_DONE;
                end
            end
            bwsc_pkg::ST_DONE: begin
                if (!r_out_valid) begin
                    n_state = bwsc_pkg::ST_IDLE;
                end
            end
            default: n_state = bwsc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop    = 1'b0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            bwsc_pkg::ST_IDLE:  o_q_pop    = i_q_valid;
            bwsc_pkg::ST_RUN:   w_issue    = (r_idx != r_n);
            bwsc_pkg::ST_DRAIN: w_load_out = 1'b0;
            bwsc_pkg::ST_DONE:  w_load_out = !r_out_valid;
            default:            o_q_pop    = 1'b0;
        endcase
    end

    assign w_mem_we = o_q_pop && !w_is_test;
    assign w_latch  = o_q_pop && w_is_test;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bwsc_pkg::ST_IDLE;
            r_vld       <= 4'd0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= {r_vld[2:0], w_issue};
            if (w_latch) begin
                r_idx <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // wall store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_q_data[8*CB-1 -: 4*CB];
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // test setup and hit accumulation
    always_ff @(posedge i_clk) begin
        if (w_latch) begin
            for (int k = 0; k < 4; k++) begin
                r_bx[k] <= i_q_data[(8-2*k)*CB-1 -: CB];
                r_by[k] <= i_q_data[(7-2*k)*CB-1 -: CB];
            end
            if (32'(i_wall_count) > 32'(MAX_WALLS)) begin
                r_n <= CW'(MAX_WALLS);
            end else begin
                r_n <= CW'(i_wall_count);
            end
            r_hit <= 1'b0;
        end else if (r_vld[3]) begin
            r_hit <= r_hit | (|w_cross);
        end
        if (w_load_out) begin
            r_out_hit <= r_hit;
        end
    end

    // stage 2: differences, stage 3: products, stage 4: determinants
    always_ff @(posedge i_clk) begin
        r_sx <= DW'(w_wx1) - DW'(w_wx0);
        r_sy <= DW'(w_wy1) - DW'(w_wy0);
        for (int s = 0; s < NS; s++) begin
            r_rx[s] <= DW'(r_bx[bwsc_pkg::SIDE_B[s]]) - DW'(r_bx[bwsc_pkg::SIDE_A[s]]);
            r_ry[s] <= DW'(r_by[bwsc_pkg::SIDE_B[s]]) - DW'(r_by[bwsc_pkg::SIDE_A[s]]);
            r_qx[s] <= DW'(r_bx[bwsc_pkg::SIDE_A[s]]) - DW'(w_wx0);
            r_qy[s] <= DW'(r_by[bwsc_pkg::SIDE_A[s]]) - DW'(w_wy0);

            r_pd1[s] <= r_sy * r_rx[s];
            r_pd2[s] <= r_sx * r_ry[s];
            r_pa1[s] <= r_sx * r_qy[s];
            r_pa2[s] <= r_sy * r_qx[s];
            r_pb1[s] <= r_rx[s] * r_qy[s];
            r_pb2[s] <= r_ry[s] * r_qx[s];

            r_d[s]  <= EW'(r_pd1[s]) - EW'(r_pd2[s]);
            r_na[s] <= EW'(r_pa1[s]) - EW'(r_pa2[s]);
            r_nb[s] <= EW'(r_pb1[s]) - EW'(r_pb2[s]);
        end
    end

    // parallel and collinear pairs never cross
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            w_cross[s] = (r_d[s] != 0) && in_unit(r_na[s], r_d[s])
                         && in_unit(r_nb[s], r_d[s]);
        end
    end

    assign o_empty = !r_out_valid;
    assign o_hit   = r_out_hit;

endmodule

[src/box_wall_segment_collision_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_wall_segment_collision_unit
// Tests the four sides of a box against a store of wall segments.
// ----------------------------------------------------------------------------
// Input words go in on push/full; cmd selects a wall write (corner0 and
// corner1 are the wall ends, stored at wall_slot) or a box test. Results
// come out on empty/pop, one hit word per test, none per wall write.
// The wall count register is written on the cfg valid/ready channel,
// which is always ready; write it only while the unit is idle.
// A two-word queue sits between the input side and the test engine, so
// input words are taken during a test or an unread result until it fills.
// A wall write is stored as the engine takes it from the queue. A test
// walks the walls in store order, one per cycle through a four-stage
// multiply pipeline. With n = min(wall_count, MAX_WALLS), it walks walls
// 0 to n-1; a test word taken by an idle unit gives its result once the
// pipeline has drained, and the engine takes no new word before that;
// the store read port sets the one-wall-per-cycle pace.
// With a result unread, the engine holds the next result and the queue
// fills, then full rises.
// Reset empties the queue and the result register and clears wall_count;
// the wall store itself is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module box_wall_segment_collision_unit #(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [bwsc_pkg::CMD_BITS-1:0]      i_cmd,
    input  logic [bwsc_pkg::SLOT_BITS-1:0]     i_wall_slot,
    input  logic signed [COORD_BITS-1:0]       i_corner0_x,
    input  logic signed [COORD_BITS-1:0]       i_corner0_y,
    input  logic signed [COORD_BITS-1:0]       i_corner1_x,
    input  logic signed [COORD_BITS-1:0]       i_corner1_y,
    input  logic signed [COORD_BITS-1:0]       i_corner2_x,
    input  logic signed [COORD_BITS-1:0]       i_corner2_y,
    input  logic signed [COORD_BITS-1:0]       i_corner3_x,
    input  logic signed [COORD_BITS-1:0]       i_corner3_y,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_hit,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bwsc_pkg::CFG_BITS-1:0]      i_cfg_data
);

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int QW = 1 + AW + 8 * COORD_BITS;

    logic [bwsc_pkg::CFG_BITS-1:0] r_wall_count;
    logic                          w_q_push;
    logic [QW-1:0]                 w_q_wdata;
    logic                          w_q_full;
    logic                          w_q_valid;
    logic                          w_q_pop;
    logic [QW-1:0]                 w_q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_count <= '0;
        end else if (i_cfg_valid) begin
            r_wall_count <= i_cfg_data;
        end
    end

    bwsc_front #(
        .MAX_WALLS  (MAX_WALLS),
        .COORD_BITS (COORD_BITS),
        .AW         (AW),
        .QW         (QW)
    ) u_front (
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_wall_slot (i_wall_slot),
        .i_corner0_x (i_corner0_x),
        .i_corner0_y (i_corner0_y),
        .i_corner1_x (i_corner1_x),
        .i_corner1_y (i_corner1_y),
        .i_corner2_x (i_corner2_x),
        .i_corner2_y (i_corner2_y),
        .i_corner3_x (i_corner3_x),
        .i_corner3_y (i_corner3_y),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata)
    );

    bwsc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata)
    );

    bwsc_back #(
        .MAX_WALLS  (MAX_WALLS),
        .COORD_BITS (COORD_BITS),
        .AW         (AW),
        .QW         (QW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_data     (w_q_rdata),
        .o_q_pop      (w_q_pop),
        .i_wall_count (r_wall_count),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_hit        (o_hit)
    );

endmodule
